// File: hw/rtl/swrtb_pkg.sv
// Shared types and constants for the sliding-window rate and token budget block.
// Used by the log cells, the cell chain and the top level; depends on nothing.
`default_nettype none
package swrtb_pkg;

	localparam int LOG_DEPTH_DEFAULT = 64;

	localparam int CMD_W      = 2;
	localparam int NOW_W      = 48;
	localparam int AMOUNT_W   = 32;
	localparam int MAXEV_W    = 7;
	localparam int TOKEN_W    = 31;
	localparam int WINDOW_W   = 40;
	localparam int RECENT_W   = 7;
	localparam int LEFT_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 72;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(3600000);

	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RECORD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVENTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_LIM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW     = 2'd2;

	typedef struct packed {
		logic prune;
		logic compact;
		logic insert;
		logic count;
	} swrtb_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/sliding_window_rate_and_token_budget.sv
// Top level of the sliding-window rate limiter with a token budget.
// Depends on swrtb_pkg and swrtb_log.
`default_nettype none
// The block takes one command per transfer and returns one result per transfer. The event log
// is a row of LOG_DEPTH cells; the token count, the limits and the result register sit here.
// A query or an add-tokens command runs the count, which ripples once through the row of cells,
// before the next command is accepted. A record command first drops expired entries, then
// closes the gaps they leave, then appends the new timestamp, and then the count runs as for a
// query. A finished result waits in the output register while the next command is taken.
module sliding_window_rate_and_token_budget #(
	parameter int LOG_DEPTH = swrtb_pkg::LOG_DEPTH_DEFAULT
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// now [47:0], token_amount [79:48]
	input  wire  [swrtb_pkg::IN_DATA_W-1:0]      s_tdata,
	// command [1:0]
	input  wire  [swrtb_pkg::CMD_W-1:0]          s_tuser,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// allowed [0], recent_events [7:1], tokens_spent [38:8], tokens_left [70:39],
	// log_overflow [71]
	output logic [swrtb_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  wire                                  cfg_we,
	input  wire  [swrtb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [swrtb_pkg::WINDOW_W-1:0]       cfg_wdata
);

	localparam int SUM_W = $clog2(LOG_DEPTH + 1);
	localparam int CNT_W = $clog2(LOG_DEPTH + 1);
	localparam int CMP_W = (SUM_W > swrtb_pkg::MAXEV_W) ? SUM_W : swrtb_pkg::MAXEV_W;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_PRUNE   = 3'd1;
	localparam logic [2:0] ST_COMPACT = 3'd2;
	localparam logic [2:0] ST_INSERT  = 3'd3;
	localparam logic [2:0] ST_COUNT   = 3'd4;
	localparam logic [2:0] ST_DONE    = 3'd5;

	logic [swrtb_pkg::MAXEV_W-1:0]   max_q;
	logic [swrtb_pkg::TOKEN_W-1:0]   limit_q;
	logic [swrtb_pkg::WINDOW_W-1:0]  window_q;
	logic [swrtb_pkg::TOKEN_W-1:0]   tok_q;
	logic [swrtb_pkg::NOW_W-1:0]     now_q;
	logic [swrtb_pkg::NOW_W-1:0]     cut_q;
	logic                            ovf_q;
	logic [2:0]                      state_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            out_valid_q;
	logic [swrtb_pkg::OUT_DATA_W-1:0] out_data_q;

	logic                            in_xfer;
	logic                            load_out;
	logic                            cnt_last;
	logic [swrtb_pkg::NOW_W-1:0]     in_now;
	logic [swrtb_pkg::AMOUNT_W-1:0]  in_amt;
	logic [swrtb_pkg::NOW_W:0]       cut_diff;
	logic [swrtb_pkg::TOKEN_W:0]     tok_sum;
	logic                            amt_pos;
	swrtb_pkg::swrtb_ctl_t           ctl;
	logic [LOG_DEPTH-1:0]            vld;
	logic                            full;
	logic [SUM_W-1:0]                total;
	logic                            events_ok;
	logic                            budget_ok;
	logic [swrtb_pkg::LEFT_W-1:0]    left;

	assign in_now   = s_tdata[swrtb_pkg::NOW_W-1:0];
	assign in_amt   = s_tdata[swrtb_pkg::NOW_W +: swrtb_pkg::AMOUNT_W];
	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign cnt_last = (cnt_q == CNT_W'(LOG_DEPTH - 1));
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	assign cut_diff = {1'b0, in_now} - (swrtb_pkg::NOW_W + 1)'(window_q);
	assign amt_pos  = !in_amt[swrtb_pkg::AMOUNT_W-1] && (in_amt != '0);
	assign tok_sum  = {1'b0, tok_q} + {1'b0, in_amt[swrtb_pkg::TOKEN_W-1:0]};

	assign ctl.prune   = (state_q == ST_PRUNE);
	assign ctl.compact = (state_q == ST_COMPACT);
	assign ctl.insert  = (state_q == ST_INSERT);
	assign ctl.count   = (state_q == ST_COUNT);

	swrtb_log #(
		.LOG_DEPTH(LOG_DEPTH),
		.SUM_W    (SUM_W)
	) u_log (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.cut   (cut_q),
		.now   (now_q),
		.vld   (vld),
		.full  (full),
		.total (total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= '0;
			limit_q  <= '0;
			window_q <= swrtb_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				swrtb_pkg::CFG_MAX_EVENTS: max_q    <= cfg_wdata[swrtb_pkg::MAXEV_W-1:0];
				swrtb_pkg::CFG_TOKEN_LIM:  limit_q  <= cfg_wdata[swrtb_pkg::TOKEN_W-1:0];
				swrtb_pkg::CFG_WINDOW:     window_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (in_xfer) begin
			case (s_tuser)
				swrtb_pkg::CMD_RECORD: tok_q <= '0;
				swrtb_pkg::CMD_ADD: begin
					if (amt_pos) begin
						tok_q <= tok_sum[swrtb_pkg::TOKEN_W] ? '1 : tok_sum[swrtb_pkg::TOKEN_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			now_q <= in_now;
			cut_q <= cut_diff[swrtb_pkg::NOW_W] ? '0 : cut_diff[swrtb_pkg::NOW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_xfer) begin
						ovf_q   <= 1'b0;
						state_q <= (s_tuser == swrtb_pkg::CMD_RECORD) ? ST_PRUNE : ST_COUNT;
					end
				end
				ST_PRUNE: begin
					cnt_q   <= '0;
					state_q <= ST_COMPACT;
				end
				ST_COMPACT: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_last) begin
						state_q <= ST_INSERT;
					end
				end
				ST_INSERT: begin
					cnt_q   <= '0;
					ovf_q   <= full;
					state_q <= ST_COUNT;
				end
				ST_COUNT: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign events_ok = (max_q == '0) || (CMP_W'(total) < CMP_W'(max_q));
	assign budget_ok = (limit_q == '0) || (tok_q < limit_q);

	always_comb begin
		if (limit_q == '0) begin
			left = '1;
		end else if (limit_q > tok_q) begin
			left = {1'b0, limit_q - tok_q};
		end else begin
			left = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {ovf_q, left, tok_q, swrtb_pkg::RECENT_W'(total),
				events_ok && budget_ok};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_log_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((vld & (vld + LOG_DEPTH'(1))) == '0))
		else $error("Valid log entries do not form a prefix of the cell row.");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && ovf_q) |-> (total == SUM_W'(LOG_DEPTH)))
		else $error("Overflow reported while the log is not full.");

	a_record_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_tuser == swrtb_pkg::CMD_RECORD) |=> (tok_q == '0))
		else $error("Token count not cleared by a record command.");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/swrtb_cell.sv
// One cell of the event log: a timestamp, its valid bit and a partial event count.
// Depends on swrtb_pkg for the control struct and the timestamp width.
`default_nettype none
module swrtb_cell #(
	parameter int SUM_W = 7
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  swrtb_pkg::swrtb_ctl_t         ctl,
	input  wire                           full,
	input  wire  [swrtb_pkg::NOW_W-1:0]   cut,
	input  wire  [swrtb_pkg::NOW_W-1:0]   now,
	input  wire                           low_v,
	input  wire  [SUM_W-1:0]              low_sum,
	input  wire  [swrtb_pkg::NOW_W-1:0]   up_ts,
	input  wire                           up_v,
	output logic [swrtb_pkg::NOW_W-1:0]   ts,
	output logic                          v,
	output logic [SUM_W-1:0]              sum
);

	logic [swrtb_pkg::NOW_W-1:0] ts_q;
	logic                        v_q;
	logic [SUM_W-1:0]            sum_q;
	logic                        hit;

	assign hit = v_q && (ts_q >= cut);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ctl.prune) begin
			v_q <= hit;
		end else if (ctl.compact) begin
			if (!v_q) begin
				v_q <= up_v;
			end else if (!low_v) begin
				v_q <= 1'b0;
			end
		end else if (ctl.insert) begin
			if (full) begin
				v_q <= up_v;
			end else if (!v_q && low_v) begin
				v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((ctl.compact && !v_q) || (ctl.insert && full)) begin
			ts_q <= up_ts;
		end else if (ctl.insert && !v_q && low_v) begin
			ts_q <= now;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.count) begin
			sum_q <= low_sum + SUM_W'(hit);
		end
	end

	assign ts  = ts_q;
	assign v   = v_q;
	assign sum = sum_q;

endmodule
`default_nettype wire

// File: hw/rtl/swrtb_log.sv
// The event log as a row of swrtb_cell instances, oldest entry in cell zero.
// Depends on swrtb_pkg and swrtb_cell.
`default_nettype none
module swrtb_log #(
	parameter int LOG_DEPTH = swrtb_pkg::LOG_DEPTH_DEFAULT,
	parameter int SUM_W     = $clog2(LOG_DEPTH + 1)
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  swrtb_pkg::swrtb_ctl_t         ctl,
	input  wire  [swrtb_pkg::NOW_W-1:0]   cut,
	input  wire  [swrtb_pkg::NOW_W-1:0]   now,
	output logic [LOG_DEPTH-1:0]          vld,
	output logic                          full,
	output logic [SUM_W-1:0]              total
);

	logic [swrtb_pkg::NOW_W-1:0] ts_w  [LOG_DEPTH];
	logic [SUM_W-1:0]            sum_w [LOG_DEPTH];

	assign full  = vld[LOG_DEPTH-1];
	assign total = sum_w[LOG_DEPTH-1];

	for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
		logic                        low_v;
		logic [SUM_W-1:0]            low_sum;
		logic [swrtb_pkg::NOW_W-1:0] up_ts;
		logic                        up_v;

		if (i == 0) begin : g_head
			assign low_v   = 1'b1;
			assign low_sum = '0;
		end else begin : g_body
			assign low_v   = vld[i-1];
			assign low_sum = sum_w[i-1];
		end

		if (i == LOG_DEPTH - 1) begin : g_tail
			assign up_ts = now;
			assign up_v  = ctl.insert;
		end else begin : g_mid
			assign up_ts = ts_w[i+1];
			assign up_v  = vld[i+1];
		end

		swrtb_cell #(
			.SUM_W(SUM_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.full   (full),
			.cut    (cut),
			.now    (now),
			.low_v  (low_v),
			.low_sum(low_sum),
			.up_ts  (up_ts),
			.up_v   (up_v),
			.ts     (ts_w[i]),
			.v      (vld[i]),
			.sum    (sum_w[i])
		);
	end

endmodule
`default_nettype wire

// File: tb/sliding_window_rate_and_token_budget_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sliding-window rate limiter with a token budget.
// Random streams of commands are checked against an internal admission predictor.
// Depends on swrtb_pkg and the sliding_window_rate_and_token_budget top level.
import swrtb_pkg::*;

typedef struct packed {
	logic                overflow;
	logic [LEFT_W-1:0]   left;
	logic [TOKEN_W-1:0]  spent;
	logic [RECENT_W-1:0] recent;
	logic                allowed;
} status_t;

class admission_predictor;
	logic [MAXEV_W-1:0] event_limit;
	logic [TOKEN_W-1:0] token_limit;
	logic [WINDOW_W-1:0] window;
	logic [NOW_W-1:0] stamps [LOG_DEPTH_DEFAULT];
	int fill;
	logic [TOKEN_W-1:0] tokens;
	status_t expected_status [$];
	int mismatches;
	int results_seen;

	function new();
		event_limit = '0;
		token_limit = '0;
		window = WINDOW_RESET;
		fill = 0;
		tokens = '0;
		mismatches = 0;
		results_seen = 0;
	endfunction

	function void note_config(logic [CFG_IDX_W-1:0] index, logic [WINDOW_W-1:0] value);
		case (index)
			CFG_MAX_EVENTS: event_limit = value[MAXEV_W-1:0];
			CFG_TOKEN_LIM:  token_limit = value[TOKEN_W-1:0];
			CFG_WINDOW:     window = value;
			default: ;
		endcase
	endfunction

	function void note_command(logic [CMD_W-1:0] cmd, logic [NOW_W-1:0] now,
			logic [AMOUNT_W-1:0] amount);
		logic [NOW_W-1:0] cutoff;
		logic [TOKEN_W:0] sum;
		int keep;
		int recent;
		status_t want;
		cutoff = (NOW_W'(window) > now) ? '0 : now - NOW_W'(window);
		want.overflow = 1'b0;
		if (cmd == CMD_RECORD) begin
			keep = 0;
			for (int i = 0; i < fill; i++) begin
				if (stamps[i] >= cutoff) begin
					stamps[keep] = stamps[i];
					keep++;
				end
			end
			fill = keep;
			if (fill == LOG_DEPTH_DEFAULT) begin
				for (int i = 1; i < fill; i++) begin
					stamps[i-1] = stamps[i];
				end
				fill--;
				want.overflow = 1'b1;
			end
			stamps[fill] = now;
			fill++;
			tokens = '0;
		end else if (cmd == CMD_ADD && !amount[AMOUNT_W-1] && amount != '0) begin
			sum = {1'b0, tokens} + amount[TOKEN_W:0];
			tokens = sum[TOKEN_W] ? '1 : sum[TOKEN_W-1:0];
		end
		recent = 0;
		for (int i = 0; i < fill; i++) begin
			if (stamps[i] >= cutoff) begin
				recent++;
			end
		end
		want.recent = RECENT_W'(recent);
		want.spent = tokens;
		want.allowed = (event_limit == '0 || recent < event_limit) &&
			(token_limit == '0 || tokens < token_limit);
		if (token_limit == '0) begin
			want.left = '1;
		end else if (token_limit > tokens) begin
			want.left = LEFT_W'(token_limit - tokens);
		end else begin
			want.left = '0;
		end
		expected_status.insert(expected_status.size(), want);
	endfunction

	task report_mismatch(string what);
		if (mismatches < 50) begin
			$display("result %0d: %s", results_seen, what);
		end
		mismatches++;
	endtask

	task check_status(logic [OUT_DATA_W-1:0] data);
		status_t got;
		status_t want;
		got = status_t'(data);
		results_seen++;
		if (expected_status.size() == 0) begin
			report_mismatch($sformatf("unexpected transfer %h", data));
			return;
		end
		want = expected_status.pop_front();
		if (got.allowed !== want.allowed) begin
			report_mismatch($sformatf("allowed %b, expected %b", got.allowed, want.allowed));
		end
		if (got.recent !== want.recent) begin
			report_mismatch($sformatf("recent_events %0d, expected %0d", got.recent, want.recent));
		end
		if (got.spent !== want.spent) begin
			report_mismatch($sformatf("tokens_spent %0d, expected %0d", got.spent, want.spent));
		end
		if (got.left !== want.left) begin
			report_mismatch($sformatf("tokens_left %h, expected %h", got.left, want.left));
		end
		if (got.overflow !== want.overflow) begin
			report_mismatch($sformatf("log_overflow %b, expected %b", got.overflow, want.overflow));
		end
	endtask
endclass

module sliding_window_rate_and_token_budget_test;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int PRESSURE_AT = 100;
	localparam int PRESSURE_CYCLES = 3000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [CMD_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WINDOW_W-1:0] cfg_wdata;

	admission_predictor predictor = new();
	int burst_left = 0;
	int inputs_taken = 0;
	int cycle_count = 0;

	sliding_window_rate_and_token_budget #(
		.LOG_DEPTH(LOG_DEPTH_DEFAULT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predictor.note_command(s_tuser, s_tdata[NOW_W-1:0], s_tdata[NOW_W +: AMOUNT_W]);
				inputs_taken++;
			end
			if (m_tvalid && m_tready) begin
				predictor.check_status(m_tdata);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// The receiver keeps switching between random stall behaviors and, once, holds off
	// long enough for the block to back up into its input.
	initial begin
		int mode;
		logic [31:0] pattern;
		logic rdy;
		bit pressure_done;
		m_tready <= 1'b0;
		pressure_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!pressure_done && inputs_taken >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				m_tready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			pattern = $urandom;
			for (int k = 0; k < 64; k++) begin
				case (mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					2: rdy = ($urandom_range(0, 7) == 0);
					default: rdy = pattern[k % 32];
				endcase
				m_tready <= rdy;
				@(posedge clk);
			end
		end
	end

	function automatic logic [63:0] rand_below(input logic [63:0] n);
		return {$urandom, $urandom} % n;
	endfunction

	function automatic logic [AMOUNT_W-1:0] random_amount(input int unsigned scale);
		logic [AMOUNT_W-1:0] amt;
		case ($urandom_range(0, 9))
			0: amt = '0;
			1, 2: amt = 32'($urandom) | 32'h8000_0000;
			3: amt = 32'($urandom) & 32'h7FFF_FFFF;
			default: amt = 32'($urandom_range(1, scale));
		endcase
		return amt;
	endfunction

	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [NOW_W-1:0] now,
			input logic [AMOUNT_W-1:0] amt);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 160);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {amt, now};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [WINDOW_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		predictor.note_config(index, value);
	endtask

	// Unused upper bits of the narrower registers may carry noise; only the low bits count.
	task automatic configure(input logic [MAXEV_W-1:0] ev, input logic [TOKEN_W-1:0] lim,
			input logic [WINDOW_W-1:0] win, input bit noisy);
		logic [WINDOW_W-1:0] noise;
		noise = noisy ? WINDOW_W'({$urandom, $urandom}) : '0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (predictor.expected_status.size() != 0) @(posedge clk);
		write_register(CFG_MAX_EVENTS, {noise[WINDOW_W-1:MAXEV_W], ev});
		write_register(CFG_TOKEN_LIM, {noise[WINDOW_W-1:TOKEN_W], lim});
		write_register(CFG_WINDOW, win);
		cfg_we <= 1'b0;
		burst_left = 0;
	endtask

	task automatic run_phase(input int count, input int record_pct, input logic [63:0] step,
			input logic [NOW_W-1:0] start, input int unsigned scale);
		logic [NOW_W-1:0] t;
		logic [CMD_W-1:0] cmd;
		int r;
		t = start;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < record_pct) begin
				cmd = CMD_RECORD;
			end else if (r < record_pct + (96 - record_pct) / 2) begin
				cmd = CMD_ADD;
			end else if (r < 96) begin
				cmd = CMD_QUERY;
			end else begin
				cmd = CMD_SPARE;
			end
			r = $urandom_range(0, 99);
			if (r < 4) begin
				t = t - NOW_W'(rand_below(step * 4 + 1));
			end else if (r < 8) begin
				t = t + NOW_W'(rand_below(step * 64 + 1));
			end else begin
				t = t + NOW_W'(rand_below(step + 1));
			end
			send_command(cmd, t, random_amount(scale));
		end
	endtask

	initial begin
		logic [MAXEV_W-1:0] ev;
		logic [TOKEN_W-1:0] lim;
		logic [WINDOW_W-1:0] win;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(CMD_QUERY, 48'd0, 32'd0);
		send_command(CMD_RECORD, 48'd0, 32'd0);
		send_command(CMD_SPARE, 48'd5, 32'd100);
		send_command(CMD_ADD, 48'd10, 32'd0);
		send_command(CMD_ADD, 48'd11, 32'hFFFF_FFFF);
		send_command(CMD_ADD, 48'd12, 32'h8000_0000);
		send_command(CMD_ADD, 48'd13, 32'h7FFF_FFFF);
		send_command(CMD_ADD, 48'd14, 32'd1);
		send_command(CMD_QUERY, 48'd15, 32'hFFFF_FFFF);
		send_command(CMD_RECORD, 48'd1000, 32'h1234_5678);
		send_command(CMD_ADD, 48'd1001, 32'd5);
		send_command(CMD_RECORD, 48'd3601000, 32'd0);
		send_command(CMD_QUERY, 48'd3601001, 32'd0);
		send_command(CMD_RECORD, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF);
		send_command(CMD_QUERY, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_command(CMD_RECORD, 48'd100, 32'd0);
		send_command(CMD_QUERY, 48'hFFFF_FFFF_FFFF, 32'd0);
		send_command(CMD_ADD, 48'hAAAA_AAAA_AAAA, 32'h5555_5555);
		send_command(CMD_ADD, 48'h5555_5555_5555, 32'h2AAA_AAAA);
		send_command(CMD_SPARE, 48'd0, 32'hAAAA_AAAA);
		send_command(CMD_RECORD, 48'h5555_5555_5555, 32'd0);

		// Event limit at the log depth, widest token limit and window with dense records, so the log fills and overflows.
		configure(7'd64, 31'h7FFF_FFFF, 40'hFF_FFFF_FFFF, 1'b0);
		run_phase(160, 70, 64'd1000, 48'h0000_1000_0000, 32'h2000_0000);
		configure(7'd1, 31'd1, 40'd1, 1'b0);
		run_phase(80, 40, 64'd2, 48'h8000_0000_0000, 2);
		// Event limit beyond the log depth, unlimited tokens and a zero-length window.
		configure(7'd127, 31'd0, 40'd0, 1'b0);
		run_phase(80, 50, 64'd3, NOW_W'(rand_below(64'h1_0000_0000_0000)), 100);

		for (int p = 0; p < 5; p++) begin
			ev = ($urandom_range(0, 5) == 0) ? 7'd127 : 7'($urandom_range(0, 64));
			case ($urandom_range(0, 2))
				0: lim = '0;
				1: lim = 31'($urandom_range(1, 1000));
				default: lim = 31'($urandom);
			endcase
			case ($urandom_range(0, 2))
				0: win = 40'($urandom_range(1, 100));
				1: win = 40'($urandom_range(1000, 1000000));
				default: win = 40'(rand_below(64'h100_0000_0000));
			endcase
			configure(ev, lim, win, 1'($urandom_range(0, 1)));
			run_phase(85, $urandom_range(20, 60), 64'(win) / $urandom_range(2, 40) + 1,
				NOW_W'(rand_below(64'h1_0000_0000_0000)), (lim == '0) ? 1000 : lim / 3 + 1);
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (predictor.expected_status.size() != 0) @(posedge clk);
		repeat (2 * LOG_DEPTH_DEFAULT + 8) @(posedge clk);
		if (predictor.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

// File: sliding_window_rate_and_token_budget.f
hw/rtl/swrtb_pkg.sv
hw/rtl/swrtb_cell.sv
hw/rtl/swrtb_log.sv
hw/rtl/sliding_window_rate_and_token_budget.sv
tb/sliding_window_rate_and_token_budget_test.sv
